/* design/bdr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the button debounce / repeat / long-press unit.
// No dependencies; bdr_cfg, bdr_ctrl, bdr_dpath and the top level import this package.
package bdr_pkg;

    // Configuration register indexes (word index on the APB port)
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_REPEAT   = 2'd1;
    localparam logic [1:0] REG_LONG     = 2'd2;
    localparam logic [1:0] REG_ACTIVE   = 2'd3;

    // Register reset values
    localparam logic [15:0] DEBOUNCE_RST = 16'd50;
    localparam logic [15:0] REPEAT_RST   = 16'd300;
    localparam logic [15:0] LONG_RST     = 16'd1000;
    localparam logic        ACTIVE_RST   = 1'b0;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] repeat_ms;
        logic [15:0] long_ms;
        logic        active_level;
    } bdr_cfg_t;

    typedef struct packed {
        logic [2:0]  button_id;
        logic        edge_seen;
        logic        pin_level;
        logic [31:0] now_ms;
        logic        sleeping;
    } bdr_poll_t;

    typedef struct packed {
        logic [2:0] out_button;
        logic       accepted;
        logic       notify;
        logic       level_out;
        logic       changed;
        logic       repeated;
        logic       long_press;
        logic [7:0] repeat_total;
        logic [7:0] long_total;
    } bdr_result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // load the incoming request
        logic evaluate;  // read button state, run tests and products
        logic commit;    // write back state and load the result register
    } bdr_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WB
    } bdr_state_t;

endpackage

/* design/bdr_poll_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel carrying one button poll request.
// Standalone; no package dependency.
interface bdr_poll_if;
    logic        valid;
    logic        ready;
    logic [2:0]  button_id;
    logic        edge_seen;
    logic        pin_level;
    logic [31:0] now_ms;
    logic        sleeping;

    modport source (output valid, output button_id, output edge_seen, output pin_level,
                    output now_ms, output sleeping, input ready);
    modport sink (input valid, input button_id, input edge_seen, input pin_level,
                  input now_ms, input sleeping, output ready);
endinterface

/* design/bdr_result_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel carrying one poll result.
// Standalone; no package dependency.
interface bdr_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] out_button;
    logic       accepted;
    logic       notify;
    logic       level_out;
    logic       changed;
    logic       repeated;
    logic       long_press;
    logic [7:0] repeat_total;
    logic [7:0] long_total;

    modport source (output valid, output out_button, output accepted, output notify,
                    output level_out, output changed, output repeated, output long_press,
                    output repeat_total, output long_total, input ready);
    modport sink (input valid, input out_button, input accepted, input notify,
                  input level_out, input changed, input repeated, input long_press,
                  input repeat_total, input long_total, output ready);
endinterface

/* design/bdr_cfg.sv */
`timescale 1ns / 1ps
// APB-style configuration registers: debounce, repeat and long periods, active level.
// Depends on bdr_pkg.
module bdr_cfg
    import bdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output bdr_cfg_t    cfg
);

    logic [15:0] debounce_ms_reg;
    logic [15:0] repeat_ms_reg;
    logic [15:0] long_ms_reg;
    logic        active_level_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg  <= DEBOUNCE_RST;
            repeat_ms_reg    <= REPEAT_RST;
            long_ms_reg      <= LONG_RST;
            active_level_reg <= ACTIVE_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_DEBOUNCE: debounce_ms_reg  <= pwdata[15:0];
                REG_REPEAT:   repeat_ms_reg    <= pwdata[15:0];
                REG_LONG:     long_ms_reg      <= pwdata[15:0];
                REG_ACTIVE:   active_level_reg <= pwdata[0];
                default:      ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (paddr[3:2])
            REG_DEBOUNCE: prdata = {16'd0, debounce_ms_reg};
            REG_REPEAT:   prdata = {16'd0, repeat_ms_reg};
            REG_LONG:     prdata = {16'd0, long_ms_reg};
            REG_ACTIVE:   prdata = {31'd0, active_level_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.debounce_ms  = debounce_ms_reg;
    assign cfg.repeat_ms    = repeat_ms_reg;
    assign cfg.long_ms      = long_ms_reg;
    assign cfg.active_level = active_level_reg;

endmodule

/* design/bdr_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences capture, evaluate and commit, owns both handshakes.
// Depends on bdr_pkg.
module bdr_ctrl
    import bdr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output bdr_cmd_t cmd
);

    bdr_state_t state_reg;
    bdr_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.evaluate = 1'b0;
        cmd.commit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.evaluate = 1'b1;
                state_next   = ST_WB;
            end
            ST_WB:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

/* design/bdr_dpath.sv */
`timescale 1ns / 1ps
// Datapath: per-button state, debounce/trigger tests, period compares, result register.
// Depends on bdr_pkg.
module bdr_dpath
    import bdr_pkg::*;
#(
    parameter int NUM_BUTTONS = 8,
    parameter int COUNT_BITS  = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  bdr_cmd_t    cmd,
    input  bdr_cfg_t    cfg,
    input  bdr_poll_t   poll_in,
    output bdr_result_t result_out
);

    localparam int IDX_W  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int PROD_W = COUNT_BITS + 17;
    localparam int CMP_W  = (PROD_W > 32) ? PROD_W : 32;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [6:0] NB = 7'(NUM_BUTTONS);

    // Per-button state
    logic                  held_level_reg   [NUM_BUTTONS];
    logic [31:0]           last_accept_reg  [NUM_BUTTONS];
    logic [31:0]           change_time_reg  [NUM_BUTTONS];
    logic [COUNT_BITS-1:0] long_count_reg   [NUM_BUTTONS];
    logic [COUNT_BITS-1:0] repeat_count_reg [NUM_BUTTONS];

    // Captured request
    logic [2:0]       id_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             edge_reg;
    logic             pin_reg;
    logic [31:0]      now_reg;
    logic             sleep_reg;

    // Evaluation results
    logic                  pass_reg;
    logic                  chg_reg;
    logic                  pressed_reg;
    logic [31:0]           held_reg;
    logic [COUNT_BITS-1:0] lc_reg;
    logic [COUNT_BITS-1:0] rc_reg;
    logic [PROD_W-1:0]     prod_l_reg;
    logic [PROD_W-1:0]     prod_r_reg;

    bdr_result_t res_reg;

    // Evaluate-stage signals
    logic                  cur_level;
    logic [31:0]           cur_change;
    logic [31:0]           cur_last;
    logic [COUNT_BITS-1:0] cur_lc;
    logic [COUNT_BITS-1:0] cur_rc;
    logic [31:0]           since_change;
    logic [31:0]           since_accept;
    logic                  id_ok;
    logic                  trig;
    logic                  pass;
    logic                  chg;
    logic                  new_level;
    logic [31:0]           held;
    logic [COUNT_BITS:0]   lc_inc;
    logic [COUNT_BITS:0]   rc_inc;

    // Commit-stage signals
    logic                  lng;
    logic                  rep;
    logic [COUNT_BITS-1:0] lc_new;
    logic [COUNT_BITS-1:0] rc_new;
    logic                  release_clr;

    // Capture request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            id_reg    <= poll_in.button_id;
            idx_reg   <= IDX_W'(poll_in.button_id);
            edge_reg  <= poll_in.edge_seen;
            pin_reg   <= poll_in.pin_level;
            now_reg   <= poll_in.now_ms;
            sleep_reg <= poll_in.sleeping;
        end
    end

    // Trigger and debounce tests on the addressed button
    always_comb
    begin
        cur_level    = held_level_reg[idx_reg];
        cur_change   = change_time_reg[idx_reg];
        cur_last     = last_accept_reg[idx_reg];
        cur_lc       = long_count_reg[idx_reg];
        cur_rc       = repeat_count_reg[idx_reg];
        since_change = now_reg - cur_change;
        since_accept = now_reg - cur_last;
        id_ok        = {4'd0, id_reg} < NB;
        trig         = edge_reg ||
                       ((cur_level == cfg.active_level) &&
                        (since_change > {16'd0, cfg.repeat_ms}));
        pass         = id_ok && trig && (since_accept > {16'd0, cfg.debounce_ms});
        // an edge restarts the held time at zero
        held         = edge_reg ? 32'd0 : since_change;
        chg          = (pin_reg != cur_level);
        new_level    = chg ? pin_reg : cur_level;
        lc_inc       = {1'b0, cur_lc} + (COUNT_BITS+1)'(1);
        rc_inc       = {1'b0, cur_rc} + (COUNT_BITS+1)'(1);
    end

    // quotient > count  <=>  held >= (count + 1) * period; period zero always advances
    always_ff @(posedge clk)
    begin
        if (cmd.evaluate)
        begin
            pass_reg    <= pass;
            chg_reg     <= chg;
            pressed_reg <= (new_level == cfg.active_level);
            held_reg    <= held;
            lc_reg      <= cur_lc;
            rc_reg      <= cur_rc;
            prod_l_reg  <= PROD_W'(lc_inc) * PROD_W'(cfg.long_ms);
            prod_r_reg  <= PROD_W'(rc_inc) * PROD_W'(cfg.repeat_ms);
        end
    end

    // Count advance and release clearing
    always_comb
    begin
        lng = pass_reg && pressed_reg && (lc_reg != CNT_MAX) &&
              (CMP_W'(held_reg) >= CMP_W'(prod_l_reg));
        rep = pass_reg && pressed_reg && (rc_reg != CNT_MAX) &&
              (CMP_W'(held_reg) >= CMP_W'(prod_r_reg));
        lc_new = lc_reg + COUNT_BITS'(lng);
        rc_new = rc_reg + COUNT_BITS'(rep);
        release_clr = chg_reg && (pin_reg != cfg.active_level);
    end

    // Per-button state write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                held_level_reg[i]   <= ~ACTIVE_RST;
                last_accept_reg[i]  <= 32'd0;
                change_time_reg[i]  <= 32'd0;
                long_count_reg[i]   <= '0;
                repeat_count_reg[i] <= '0;
            end
        end
        else if (cmd.commit && pass_reg)
        begin
            last_accept_reg[idx_reg] <= now_reg;
            if (edge_reg || chg_reg)
                change_time_reg[idx_reg] <= now_reg;
            if (chg_reg)
                held_level_reg[idx_reg] <= pin_reg;
            if (release_clr)
            begin
                long_count_reg[idx_reg]   <= '0;
                repeat_count_reg[idx_reg] <= '0;
            end
            else
            begin
                long_count_reg[idx_reg]   <= lc_new;
                repeat_count_reg[idx_reg] <= rc_new;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_reg.out_button   <= id_reg;
            res_reg.accepted     <= pass_reg;
            res_reg.notify       <= pass_reg && (chg_reg || rep || lng) && !sleep_reg;
            res_reg.level_out    <= pass_reg && pin_reg;
            res_reg.changed      <= pass_reg && chg_reg;
            res_reg.repeated     <= rep;
            res_reg.long_press   <= lng;
            res_reg.repeat_total <= pass_reg ? 8'(rc_new) : 8'd0;
            res_reg.long_total   <= pass_reg ? 8'(lc_new) : 8'd0;
        end
    end

    assign result_out = res_reg;

endmodule

/* design/button_debounce_repeat_longpress_unit.sv */
`timescale 1ns / 1ps
// Button debounce with auto-repeat and long-press counting, top level.
// Depends on bdr_pkg, bdr_poll_if, bdr_result_if, bdr_cfg, bdr_ctrl, bdr_dpath.
//
// Usage:
//   poll   : valid/ready sink; one request is one poll of one button (id, edge
//            flag, pin level, millisecond time, sleeping flag).
//   result : valid/ready source; exactly one result per poll, in order.
//   APB    : debounce_ms at 0x0, repeat_ms at 0x4, long_ms at 0x8, active_level
//            at 0xC; write only while no poll is in flight. pready is tied high.
// Timing: a poll is accepted, evaluated in the next cycle (state read, trigger
//   and debounce tests, period products), and then committed in the write-back
//   step, which sets the registered result valid. poll.ready is high only in
//   the idle state, so a new poll is taken only after the three-step controller
//   sequence has committed the last one.
// The result sits in an output register, so a new poll is taken while the last
//   result waits; if the receiver still stalls at commit time the block holds
//   in its commit step and poll.ready stays low until the result is taken.
// Reset: registers return to 50/300/1000/0, every button reads released with
//   zero times and counts; no clearing pass is needed.
module button_debounce_repeat_longpress_unit
    import bdr_pkg::*;
#(
    parameter int NUM_BUTTONS = 8,
    parameter int COUNT_BITS  = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    bdr_poll_if.sink     poll,
    bdr_result_if.source result
);

    bdr_cfg_t    cfg;
    bdr_cmd_t    cmd;
    bdr_poll_t   poll_in;
    bdr_result_t result_out;

    // Configuration registers
    bdr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Controller
    bdr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (poll.valid),
        .in_ready  (poll.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // Pack the request
    assign poll_in.button_id = poll.button_id;
    assign poll_in.edge_seen = poll.edge_seen;
    assign poll_in.pin_level = poll.pin_level;
    assign poll_in.now_ms    = poll.now_ms;
    assign poll_in.sleeping  = poll.sleeping;

    // Datapath
    bdr_dpath #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .poll_in    (poll_in),
        .result_out (result_out)
    );

    // Unpack the result
    assign result.out_button   = result_out.out_button;
    assign result.accepted     = result_out.accepted;
    assign result.notify       = result_out.notify;
    assign result.level_out    = result_out.level_out;
    assign result.changed      = result_out.changed;
    assign result.repeated     = result_out.repeated;
    assign result.long_press   = result_out.long_press;
    assign result.repeat_total = result_out.repeat_total;
    assign result.long_total   = result_out.long_total;

endmodule
